FILE: rtl/core/csipc_pkg.sv
// Shared types, opcodes and default sizes for the CSI parameter collector.
package csipc_pkg;

  localparam int MAX_PARAMS        = 16;
  localparam int MAX_SUBPARAMS     = 16;
  localparam int MAX_INTERMEDIATES = 5;

  typedef enum logic [2:0] {
    OP_CLEAR      = 3'd0,
    OP_CSI        = 3'd1,
    OP_INTER      = 3'd2,
    OP_READ_PARAM = 3'd3,
    OP_READ_INTER = 3'd4
  } opcode_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] in_byte;
    logic       first_param;
    logic [4:0] param_index;
    logic [4:0] sub_index;
  } in_item_t;

  typedef struct packed {
    logic        disposition;
    logic [4:0]  param_count;
    logic [4:0]  sub_count;
    logic [2:0]  intermediate_count;
    logic [7:0]  private_char;
    logic [31:0] read_value;
  } out_item_t;

endpackage

FILE: rtl/core/csipc_if.sv
// Valid/ready channel interfaces for the command and result streams.
interface csipc_in_if;
  logic               valid;
  logic               ready;
  csipc_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface csipc_out_if;
  logic                valid;
  logic                ready;
  csipc_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/csi_parameter_collector.sv
// CSI parameter collector: one command per cycle unless the output stalls.
// The block accepts one command per clock cycle while the result output is not stalled; the
// command is captured in an input register, and all state is updated as the command moves
// to the result register; a subparameter read comes from a RAM whose registered output is
// loaded in that same cycle. The digit fold into the
// current value is a shift-and-add with a saturation check, kept in a shadow register so
// no RAM read lies in the update path. While a result waits on the output, one more
// command can be taken into the input register. There is no clearing pass after reset;
// issue a clear command before feeding a sequence.
module csi_parameter_collector #(
  parameter int MaxParams        = csipc_pkg::MAX_PARAMS,
  parameter int MaxSubparams     = csipc_pkg::MAX_SUBPARAMS,
  parameter int MaxIntermediates = csipc_pkg::MAX_INTERMEDIATES
) (
  input  logic         clk,
  input  logic         rst,
  csipc_in_if.sink     cmd,
  csipc_out_if.source  rsp
);

  localparam int CntW   = $clog2(MaxParams + 1);
  localparam int PIdxW  = (MaxParams > 1) ? $clog2(MaxParams) : 1;
  localparam int SCntW  = $clog2(MaxSubparams + 1);
  localparam int SIdxW  = (MaxSubparams > 1) ? $clog2(MaxSubparams) : 1;
  localparam int ICntW  = $clog2(MaxIntermediates + 1);
  localparam int IIdxW  = (MaxIntermediates > 1) ? $clog2(MaxIntermediates) : 1;
  localparam int AddrW  = PIdxW + SIdxW;
  localparam int Depth  = 2 ** AddrW;
  localparam int PCmpW  = (CntW > 5) ? CntW : 5;
  localparam int SCmpW  = (SCntW > 5) ? SCntW : 5;
  localparam int ICmpW  = (ICntW > 5) ? ICntW : 5;

  localparam logic [7:0]  InterLo   = 8'h20;
  localparam logic [7:0]  InterHi   = 8'h2F;
  localparam logic [7:0]  DigitLo   = 8'h30;
  localparam logic [7:0]  DigitHi   = 8'h39;
  localparam logic [7:0]  SubSep    = 8'h3A;
  localparam logic [7:0]  ParamSep  = 8'h3B;
  localparam logic [7:0]  PrivLo    = 8'h3C;
  localparam logic [7:0]  PrivHi    = 8'h3F;
  localparam logic [7:0]  PassLimit = 8'hA0;
  localparam logic [31:0] SatValue  = 32'hFFFF_FFFF;

  // Handshake and pipeline registers
  logic                 a_valid;
  csipc_pkg::in_item_t  a_item;
  logic                 r_valid;
  csipc_pkg::out_item_t r_item;
  logic                 r_use_mem;
  logic [31:0]          mem_q;
  logic                 r_free;
  logic                 a_adv;

  // Sequence state
  logic [CntW-1:0]  open_params, open_params_next;
  logic [ICntW-1:0] inter_count, inter_count_next;
  logic [7:0]       private_mark, private_mark_next;
  logic [31:0]      cur_param, cur_param_next;
  logic [SCntW-1:0] cur_sc, cur_sc_next;
  logic [31:0]      cur_sub, cur_sub_next;

  logic [31:0]      param_values [MaxParams];
  logic [SCntW-1:0] sub_counts   [MaxParams];
  logic [7:0]       inter_chars  [MaxIntermediates];
  logic [31:0]      sub_mem      [Depth];

  // Write ports
  logic             pv_we;
  logic [PIdxW-1:0] pv_addr;
  logic [31:0]      pv_data;
  logic             sc_we;
  logic [PIdxW-1:0] sc_addr;
  logic [SCntW-1:0] sc_data;
  logic             ic_we;
  logic [IIdxW-1:0] ic_addr;
  logic             sm_we;
  logic [AddrW-1:0] sm_addr;
  logic [31:0]      sm_data;

  // Per-command combinational values
  logic [CntW-1:0]  open_m1;
  logic [PIdxW-1:0] cur_idx;
  logic [SCntW-1:0] cur_sc_m1;
  logic [ICntW-1:0] inter_inc;
  logic [ICntW-1:0] inter_inc_m1;
  logic [31:0]      fold_in;
  logic [35:0]      fold_wide;
  logic [31:0]      fold_out;
  logic [4:0]       pi_m1;
  logic [4:0]       si_m1;
  logic [PIdxW-1:0] rd_pidx;
  logic [SIdxW-1:0] rd_sidx;
  logic [IIdxW-1:0] rd_iidx;
  logic             p_hit;
  logic             i_hit;
  logic             disp;
  logic             use_mem;
  logic [31:0]      value;
  logic [7:0]       b;

  assign r_free    = !r_valid || rsp.ready;
  assign a_adv     = a_valid && r_free;
  assign cmd.ready = !a_valid || r_free;

  assign b         = a_item.in_byte;
  assign open_m1   = open_params - CntW'(1);
  assign cur_idx   = open_m1[PIdxW-1:0];
  assign cur_sc_m1 = cur_sc - SCntW'(1);

  // An intermediate goes to the next slot, or rewrites the last one once the store is full.
  assign inter_inc    = (inter_count < ICntW'(MaxIntermediates)) ?
                        inter_count + ICntW'(1) : inter_count;
  assign inter_inc_m1 = inter_inc - ICntW'(1);
  assign ic_addr      = inter_inc_m1[IIdxW-1:0];

  // Base-ten fold with saturation: anything past 32 bits pins the value at all ones.
  assign fold_in   = (cur_sc != '0) ? cur_sub : cur_param;
  assign fold_wide = ({4'b0, fold_in} << 3) + ({4'b0, fold_in} << 1) +
                     36'(b - DigitLo);
  assign fold_out  = (fold_wide[35:32] != 4'b0) ? SatValue : fold_wide[31:0];

  assign pi_m1   = a_item.param_index - 5'd1;
  assign si_m1   = a_item.sub_index - 5'd1;
  assign rd_pidx = pi_m1[PIdxW-1:0];
  assign rd_sidx = si_m1[SIdxW-1:0];
  assign rd_iidx = pi_m1[IIdxW-1:0];
  assign p_hit   = (a_item.param_index != 5'd0) &&
                   (PCmpW'(a_item.param_index) <= PCmpW'(open_params));
  assign i_hit   = (a_item.param_index != 5'd0) &&
                   (ICmpW'(a_item.param_index) <= ICmpW'(inter_count));

  always_comb begin
    open_params_next  = open_params;
    inter_count_next  = inter_count;
    private_mark_next = private_mark;
    cur_param_next    = cur_param;
    cur_sc_next       = cur_sc;
    cur_sub_next      = cur_sub;
    pv_we   = 1'b0;
    pv_addr = cur_idx;
    pv_data = fold_out;
    sc_we   = 1'b0;
    sc_addr = cur_idx;
    sc_data = '0;
    ic_we   = 1'b0;
    sm_we   = 1'b0;
    sm_addr = {cur_idx, cur_sc_m1[SIdxW-1:0]};
    sm_data = fold_out;
    disp    = 1'b0;
    use_mem = 1'b0;
    value   = '0;

    unique case (a_item.opcode)
      csipc_pkg::OP_CLEAR: begin
        open_params_next  = CntW'(1);
        inter_count_next  = '0;
        private_mark_next = '0;
        cur_param_next    = '0;
        cur_sc_next       = '0;
        pv_we   = 1'b1;
        pv_addr = '0;
        pv_data = '0;
        sc_we   = 1'b1;
        sc_addr = '0;
        sc_data = '0;
      end
      csipc_pkg::OP_CSI: begin
        if (b >= InterLo && b <= InterHi) begin
          inter_count_next = inter_inc;
          ic_we            = 1'b1;
        end else if (b >= DigitLo && b <= DigitHi) begin
          if (cur_sc != '0) begin
            cur_sub_next = fold_out;
            sm_we        = 1'b1;
          end else begin
            cur_param_next = fold_out;
            pv_we          = 1'b1;
          end
        end else if (b == SubSep) begin
          if (cur_sc < SCntW'(MaxSubparams)) begin
            cur_sc_next  = cur_sc + SCntW'(1);
            cur_sub_next = '0;
            sc_we   = 1'b1;
            sc_data = cur_sc + SCntW'(1);
            sm_we   = 1'b1;
            sm_addr = {cur_idx, cur_sc[SIdxW-1:0]};
            sm_data = '0;
          end
        end else if (b == ParamSep) begin
          if (open_params < CntW'(MaxParams)) begin
            open_params_next = open_params + CntW'(1);
            cur_param_next   = '0;
            cur_sc_next      = '0;
            pv_we   = 1'b1;
            pv_addr = open_params[PIdxW-1:0];
            pv_data = '0;
            sc_we   = 1'b1;
            sc_addr = open_params[PIdxW-1:0];
            sc_data = '0;
          end
        end else if (b >= PrivLo && b <= PrivHi) begin
          if (a_item.first_param) begin
            private_mark_next = b;
          end
        end else if (b > PassLimit) begin
          disp = 1'b1;
        end
      end
      csipc_pkg::OP_INTER: begin
        inter_count_next = inter_inc;
        ic_we            = 1'b1;
      end
      csipc_pkg::OP_READ_PARAM: begin
        if (p_hit) begin
          if (a_item.sub_index == 5'd0) begin
            value = param_values[rd_pidx];
          end else if (SCmpW'(a_item.sub_index) <= SCmpW'(sub_counts[rd_pidx])) begin
            use_mem = 1'b1;
          end
        end
      end
      csipc_pkg::OP_READ_INTER: begin
        if (i_hit) begin
          value = {24'b0, inter_chars[rd_iidx]};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      r_valid      <= 1'b0;
      open_params  <= CntW'(1);
      inter_count  <= '0;
      private_mark <= '0;
      cur_param    <= '0;
      cur_sc       <= '0;
      cur_sub      <= '0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        a_valid <= 1'b1;
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end
      if (a_adv) begin
        r_valid <= 1'b1;
      end else if (rsp.ready) begin
        r_valid <= 1'b0;
      end
      if (a_adv) begin
        open_params  <= open_params_next;
        inter_count  <= inter_count_next;
        private_mark <= private_mark_next;
        cur_param    <= cur_param_next;
        cur_sc       <= cur_sc_next;
        cur_sub      <= cur_sub_next;
      end
    end
  end

  // Payload registers and stores
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      a_item <= cmd.payload;
    end
    if (a_adv) begin
      r_item.disposition        <= disp;
      r_item.param_count        <= 5'(open_params_next);
      r_item.sub_count          <= 5'(cur_sc_next);
      r_item.intermediate_count <= 3'(inter_count_next);
      r_item.private_char       <= private_mark_next;
      r_item.read_value         <= value;
      r_use_mem                 <= use_mem;
      if (pv_we) begin
        param_values[pv_addr] <= pv_data;
      end
      if (sc_we) begin
        sub_counts[sc_addr] <= sc_data;
      end
      if (ic_we) begin
        inter_chars[ic_addr] <= b;
      end
    end
  end

  // Subparameter RAM: one write and one registered read per cycle, only as a command advances.
  always_ff @(posedge clk) begin
    if (a_adv && sm_we) begin
      sub_mem[sm_addr] <= sm_data;
    end
    if (a_adv) begin
      mem_q <= sub_mem[{rd_pidx, rd_sidx}];
    end
  end

  assign rsp.valid = r_valid;

  always_comb begin
    rsp.payload = r_item;
    if (r_use_mem) begin
      rsp.payload.read_value = mem_q;
    end
  end

endmodule

FILE: rtl/core/csipc_checker.sv
// Port-level checks for the CSI parameter collector, bound into the collector module.
module csipc_checker #(
  parameter int MaxParams        = csipc_pkg::MAX_PARAMS,
  parameter int MaxSubparams     = csipc_pkg::MAX_SUBPARAMS,
  parameter int MaxIntermediates = csipc_pkg::MAX_INTERMEDIATES
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 rsp_valid,
  input logic                 rsp_ready,
  input csipc_pkg::out_item_t rsp_payload
);

  // A result that is not taken stays on the port unchanged.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
    else $error("result changed while stalled");

  // A redispatched byte is a feed, so it never carries a read value.
  a_disp_no_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_payload.disposition |-> rsp_payload.read_value == 32'd0)
    else $error("redispatch with nonzero read value");

  // At least one parameter is always open, and never more than the limit.
  a_param_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (MaxParams >= 32) ||
                  (rsp_payload.param_count != 5'd0 &&
                   32'(rsp_payload.param_count) <= MaxParams))
    else $error("parameter count out of range");

  a_count_limits: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((MaxIntermediates >= 8) ||
                   32'(rsp_payload.intermediate_count) <= MaxIntermediates) &&
                  ((MaxSubparams >= 32) ||
                   32'(rsp_payload.sub_count) <= MaxSubparams))
    else $error("intermediate or subparameter count above limit");

endmodule

bind csi_parameter_collector csipc_checker #(
  .MaxParams        (MaxParams),
  .MaxSubparams     (MaxSubparams),
  .MaxIntermediates (MaxIntermediates)
) u_csipc_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_payload (rsp.payload)
);
